// ===== rtl/interface_traffic_rate_meter_defines.svh =====
// Assertion macros for the interface traffic rate meter.
// No dependencies.
`ifndef INTERFACE_TRAFFIC_RATE_METER_DEFINES_SVH
`define INTERFACE_TRAFFIC_RATE_METER_DEFINES_SVH

// assert that a implies b on the next clock
`define ITRM_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");

// assert that a implies b in the same clock
`define ITRM_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lbl failed");

`endif

// ===== rtl/itrm_pkg.sv =====
// Types and constants for the interface traffic rate meter.
// No dependencies.
package itrm_pkg;

    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_CLEAR     = 2'd1;
    localparam logic [1:0] CMD_CLEAR_ALL = 2'd2;
    localparam logic [1:0] CMD_RESERVED  = 2'd3;

    localparam logic [2:0] ST_SAMPLED     = 3'd0;
    localparam logic [2:0] ST_BASELINE    = 3'd1;
    localparam logic [2:0] ST_CNT_RESET   = 3'd2;
    localparam logic [2:0] ST_NO_ADVANCE  = 3'd3;
    localparam logic [2:0] ST_UNAVAILABLE = 3'd4;
    localparam logic [2:0] ST_CLEARED     = 3'd5;

    localparam logic [1:0] DELTA_OK    = 2'd0;
    localparam logic [1:0] DELTA_WRAP  = 2'd1;
    localparam logic [1:0] DELTA_RESET = 2'd2;

    localparam logic [63:0] WRAP_WINDOW = 64'h0000_0001_0000_0000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  iface;
        logic        rx_present;
        logic        tx_present;
        logic [63:0] rx_count;
        logic [63:0] tx_count;
        logic [63:0] sample_time;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        point_valid;
        logic [63:0] rx_total;
        logic [63:0] tx_total;
        logic        rx_rate_valid;
        logic [63:0] rx_bps;
        logic        tx_rate_valid;
        logic [63:0] tx_bps;
        logic        rx_wrapped;
        logic        tx_wrapped;
        logic        changed;
    } out_beat_t;

endpackage

// ===== rtl/itrm_queue.sv =====
// Two-entry queue between the command front and the rate back end.
// Depends on itrm_pkg.
module itrm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  itrm_pkg::in_beat_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output itrm_pkg::in_beat_t pop_data
);
    itrm_pkg::in_beat_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/itrm_divider.sv =====
// Restoring divider: floor({hi,lo}/den) for hi < den, one quotient bit a cycle.
// Depends on nothing.
module itrm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot
);
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] den_reg;
    logic [63:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic        ge;

    assign shifted = {rem_reg, lo_reg[63]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign done    = done_reg;
    assign quot    = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_hi;
            lo_reg  <= num_lo;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 64'(shifted - {1'b0, den_reg}) : shifted[63:0];
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/itrm_engine.sv =====
// Back end: record table, delta and wrap checks, rate scaling and division.
// Depends on itrm_pkg and itrm_divider.
module itrm_engine #(
    parameter int NUM_IFACES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         tps,
    input  logic                in_valid,
    output logic                in_ready,
    input  itrm_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output itrm_pkg::out_beat_t out_data
);
    localparam int IW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EVAL, S_MUL_LO, S_MUL_HI, S_SUM,
        S_DIV_RX, S_DIV_TX, S_FINISH, S_OUT
    } state_t;

    state_t state_reg;
    logic [NUM_IFACES-1:0] valid_reg;
    logic [63:0] time_mem [NUM_IFACES];
    logic [63:0] rx_mem [NUM_IFACES];
    logic [63:0] tx_mem [NUM_IFACES];
    logic [63:0] rxr_mem [NUM_IFACES];
    logic [63:0] txr_mem [NUM_IFACES];
    logic [3:0]  flg_mem [NUM_IFACES];

    itrm_pkg::in_beat_t  item_reg;
    itrm_pkg::out_beat_t res_reg;
    logic [IW-1:0] idx_reg;
    logic [63:0] ptime_reg, prx_reg, ptx_reg, prxr_reg, ptxr_reg;
    logic [3:0]  pflg_reg;
    logic [63:0] drx_reg, dtx_reg, elapsed_reg;
    logic        rxw_reg, txw_reg, cres_reg;
    logic        dir_reg;
    logic [63:0] p0_reg, p1_reg;
    logic [63:0] rxr_reg, txr_reg;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;
    logic        idx_ok;
    logic [63:0] d_cur;
    logic [63:0] lo8;
    logic [63:0] lo_sum;
    logic [63:0] hi_sum;
    logic [3:0]  flags;
    logic [65:0] rx_dlt;
    logic [65:0] tx_dlt;

    function automatic logic [65:0] delta_of(input logic [63:0] b, input logic [63:0] n);
        logic [65:0] r;
        r = '0;
        if (n >= b)
        begin
            r = {itrm_pkg::DELTA_OK, n - b};
        end
        else if (b >= itrm_pkg::ALL_ONES - itrm_pkg::WRAP_WINDOW
                 && n <= itrm_pkg::WRAP_WINDOW)
        begin
            r = {itrm_pkg::DELTA_WRAP, (itrm_pkg::ALL_ONES - b) + 64'd1 + n};
        end
        else
        begin
            r = {itrm_pkg::DELTA_RESET, 64'd0};
        end
        return r;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;
    assign idx_ok    = ({28'd0, item_reg.iface} < 32'(NUM_IFACES));
    assign rx_dlt    = delta_of(prx_reg, item_reg.rx_count);
    assign tx_dlt    = delta_of(ptx_reg, item_reg.tx_count);
    assign d_cur     = dir_reg ? dtx_reg : drx_reg;
    assign lo8       = {d_cur[60:0], 3'b000};
    assign lo_sum    = p0_reg + {p1_reg[31:0], 32'd0};
    assign hi_sum    = {32'd0, p1_reg[63:32]} + {63'd0, lo_sum < p0_reg}
                       + ({29'd0, d_cur[63:61]} * {32'd0, tps});
    assign div_start = (state_reg == S_SUM) && (hi_sum < elapsed_reg);
    assign flags     = {txw_reg, rxw_reg, ~cres_reg, ~cres_reg};

    itrm_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (hi_sum),
        .num_lo (lo_sum),
        .den    (elapsed_reg),
        .done   (div_done),
        .quot   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        idx_reg   <= IW'(in_data.iface);
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    ptime_reg <= time_mem[idx_reg];
                    prx_reg   <= rx_mem[idx_reg];
                    ptx_reg   <= tx_mem[idx_reg];
                    prxr_reg  <= rxr_mem[idx_reg];
                    ptxr_reg  <= txr_mem[idx_reg];
                    pflg_reg  <= flg_mem[idx_reg];
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg <= S_OUT;
                    if (item_reg.cmd != itrm_pkg::CMD_SAMPLE)
                    begin
                        res_reg <= '{status: itrm_pkg::ST_CLEARED, default: '0};
                        if (item_reg.cmd == itrm_pkg::CMD_CLEAR && idx_ok)
                        begin
                            valid_reg[idx_reg] <= 1'b0;
                        end
                        else if (item_reg.cmd == itrm_pkg::CMD_CLEAR_ALL)
                        begin
                            valid_reg <= '0;
                        end
                    end
                    else if (!idx_ok)
                    begin
                        res_reg <= '{status: itrm_pkg::ST_UNAVAILABLE, default: '0};
                    end
                    else if (!item_reg.rx_present || !item_reg.tx_present)
                    begin
                        res_reg <= '{status: itrm_pkg::ST_UNAVAILABLE,
                                     changed: valid_reg[idx_reg], default: '0};
                        valid_reg[idx_reg] <= 1'b0;
                    end
                    else if (!valid_reg[idx_reg])
                    begin
                        valid_reg[idx_reg]  <= 1'b1;
                        time_mem[idx_reg]   <= item_reg.sample_time;
                        rx_mem[idx_reg]     <= item_reg.rx_count;
                        tx_mem[idx_reg]     <= item_reg.tx_count;
                        rxr_mem[idx_reg]    <= 64'd0;
                        txr_mem[idx_reg]    <= 64'd0;
                        flg_mem[idx_reg]    <= 4'd0;
                        res_reg <= '{status: itrm_pkg::ST_BASELINE, point_valid: 1'b1,
                                     rx_total: item_reg.rx_count,
                                     tx_total: item_reg.tx_count,
                                     changed: 1'b1, default: '0};
                    end
                    else if (item_reg.sample_time <= ptime_reg)
                    begin
                        res_reg <= '{status: itrm_pkg::ST_NO_ADVANCE, default: '0};
                    end
                    else
                    begin
                        drx_reg     <= rx_dlt[63:0];
                        dtx_reg     <= tx_dlt[63:0];
                        rxw_reg     <= (rx_dlt[65:64] == itrm_pkg::DELTA_WRAP);
                        txw_reg     <= (tx_dlt[65:64] == itrm_pkg::DELTA_WRAP);
                        cres_reg    <= (rx_dlt[65:64] == itrm_pkg::DELTA_RESET)
                                       || (tx_dlt[65:64] == itrm_pkg::DELTA_RESET);
                        elapsed_reg <= item_reg.sample_time - ptime_reg;
                        rxr_reg     <= 64'd0;
                        txr_reg     <= 64'd0;
                        dir_reg     <= 1'b0;
                        state_reg   <= S_MUL_LO;
                    end
                end
                S_MUL_LO:
                begin
                    if (cres_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        p0_reg    <= {32'd0, lo8[31:0]} * {32'd0, tps};
                        state_reg <= S_MUL_HI;
                    end
                end
                S_MUL_HI:
                begin
                    p1_reg    <= {32'd0, lo8[63:32]} * {32'd0, tps};
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (hi_sum >= elapsed_reg)
                    begin
                        if (dir_reg)
                        begin
                            txr_reg   <= itrm_pkg::ALL_ONES;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            rxr_reg   <= itrm_pkg::ALL_ONES;
                            dir_reg   <= 1'b1;
                            state_reg <= S_MUL_LO;
                        end
                    end
                    else
                    begin
                        state_reg <= dir_reg ? S_DIV_TX : S_DIV_RX;
                    end
                end
                S_DIV_RX:
                begin
                    if (div_done)
                    begin
                        rxr_reg   <= div_q;
                        dir_reg   <= 1'b1;
                        state_reg <= S_MUL_LO;
                    end
                end
                S_DIV_TX:
                begin
                    if (div_done)
                    begin
                        txr_reg   <= div_q;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    time_mem[idx_reg] <= item_reg.sample_time;
                    rx_mem[idx_reg]   <= item_reg.rx_count;
                    tx_mem[idx_reg]   <= item_reg.tx_count;
                    rxr_mem[idx_reg]  <= rxr_reg;
                    txr_mem[idx_reg]  <= txr_reg;
                    flg_mem[idx_reg]  <= flags;
                    res_reg.status <= cres_reg ? itrm_pkg::ST_CNT_RESET
                                               : itrm_pkg::ST_SAMPLED;
                    res_reg.point_valid   <= 1'b1;
                    res_reg.rx_total      <= item_reg.rx_count;
                    res_reg.tx_total      <= item_reg.tx_count;
                    res_reg.rx_rate_valid <= ~cres_reg;
                    res_reg.tx_rate_valid <= ~cres_reg;
                    res_reg.rx_bps        <= rxr_reg;
                    res_reg.tx_bps        <= txr_reg;
                    res_reg.rx_wrapped    <= rxw_reg;
                    res_reg.tx_wrapped    <= txw_reg;
                    res_reg.changed <= !(prx_reg == item_reg.rx_count
                                         && ptx_reg == item_reg.tx_count
                                         && pflg_reg == flags
                                         && prxr_reg == rxr_reg
                                         && ptxr_reg == txr_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/interface_traffic_rate_meter.sv =====
// Top level of the interface traffic rate meter: input queue and back end.
// Depends on itrm_pkg, itrm_queue, itrm_engine and the defines header.
//
// When both rates are computed, a sample uses the shared restoring divider
// at most once per direction; clears, baselines and other short cases skip
// the multiply and divide states. A two-beat queue in front of the
// back end accepts commands while a result waits. The result register holds
// each beat until taken. Configuration ticks_per_second is written with wr_en.
`include "interface_traffic_rate_meter_defines.svh"
module interface_traffic_rate_meter #(
    parameter int NUM_IFACES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [31:0]         wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  itrm_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output itrm_pkg::out_beat_t out_data
);
    logic [31:0] tps_reg;
    logic        q_valid;
    logic        q_ready;
    itrm_pkg::in_beat_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= 32'd1000000000;
        end
        else if (wr_en)
        begin
            tps_reg <= wr_data;
        end
    end

    itrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (in_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    itrm_engine #(.NUM_IFACES(NUM_IFACES)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .tps       (tps_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `ITRM_ASSERT_NOW(a_point_status, out_valid && out_data.point_valid,
        out_data.status == itrm_pkg::ST_SAMPLED || out_data.status == itrm_pkg::ST_BASELINE
        || out_data.status == itrm_pkg::ST_CNT_RESET)
    `ITRM_ASSERT_NOW(a_reset_no_rate, out_valid && out_data.status == itrm_pkg::ST_CNT_RESET,
        !out_data.rx_rate_valid && !out_data.tx_rate_valid)
    `ITRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
